// ===== design/motor_duty_ramp_profile_defines.svh =====
// Assertion macros for the motor duty ramp profile block.
// Uses the clk and arst_n names of the module that includes it.
// Include guard keeps repeated includes harmless.
`ifndef MOTOR_DUTY_RAMP_PROFILE_DEFINES_SVH
`define MOTOR_DUTY_RAMP_PROFILE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define MDR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked out of reset
`define MDR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MDR_ASSERT_IMP(label, ante, cons)
`define MDR_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/mdr_pkg.sv =====
// Shared types and constants of the motor duty ramp profile block.
// No dependencies; imported by every module of the block.
package mdr_pkg;

	localparam int DUTY_W      = 16;
	localparam int MODE_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int OP_W        = 3;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_DUTY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_DUTY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVERRUN_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCE_STEP  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCE_FLOOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS    = 3'd7;

	// Mode bit positions
	localparam int MB_DIR      = 0;
	localparam int MB_KEEP     = 1;
	localparam int MB_CHKSTOP  = 2;
	localparam int MB_CHKSTART = 3;
	localparam int MB_BRAKE    = 4;
	localparam int MB_S_START  = 5;
	localparam int MB_S_REDUCE = 6;
	localparam int MB_S_STOP   = 7;

	// Input op codes
	localparam logic [OP_W-1:0] OP_CTRL_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_DELAY_TICK = 3'd1;
	localparam logic [OP_W-1:0] OP_START      = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP       = 3'd3;
	localparam logic [OP_W-1:0] OP_EMERGENCY  = 3'd4;
	localparam logic [OP_W-1:0] OP_REDUCE_EDG = 3'd5;
	localparam logic [OP_W-1:0] OP_STOP_EDG   = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_GAINED   = 4'd1,
		PH_CONST    = 4'd2,
		PH_OVERRUN  = 4'd3,
		PH_REDUCE   = 4'd4,
		PH_BREAK    = 4'd5,
		PH_BREAKING = 4'd6,
		PH_STOPPING = 4'd7,
		PH_STOP     = 4'd8
	} phase_t;

	// Classified command handed from front to back
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_CTRL_TICK,
		CMD_DELAY_TICK,
		CMD_START,
		CMD_STOP,
		CMD_EMERGENCY,
		CMD_REDUCE_EDGE,
		CMD_STOP_EDGE
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic refused;
		logic stop_lv;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] start_duty;
		logic [DUTY_W-1:0] gain_step;
		logic [DUTY_W-1:0] high_duty;
		logic [DUTY_W-1:0] overrun_time;
		logic [DUTY_W-1:0] reduce_step;
		logic [DUTY_W-1:0] reduce_floor;
		logic [DUTY_W-1:0] break_time;
		logic [MODE_W-1:0] mode_bits;
	} cfg_t;

endpackage

// ===== design/mdr_front.sv =====
// Front end: accepts input beats and classifies them into queue commands.
// Depends on mdr_pkg; feeds mdr_queue.
module mdr_front import mdr_pkg::*; (
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  op,
	input  logic             event_level,
	input  logic             start_level,
	input  logic             reduce_level,
	input  logic             stop_level,
	input  logic             q_full,
	output logic             q_push,
	output item_t            q_item
);

	logic start_bad;

	// Take a beat whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Check sensor positions for a start
	always_comb begin
		start_bad = 1'b0;
		if (cfg.mode_bits[MB_CHKSTART]) begin
			if (cfg.mode_bits[MB_S_START] && !start_level) start_bad = 1'b1;
			if (cfg.mode_bits[MB_S_REDUCE] && reduce_level) start_bad = 1'b1;
			if (cfg.mode_bits[MB_S_STOP] && stop_level) start_bad = 1'b1;
		end
	end

	// Classify op; drop sensor edges of absent sensors or falling levels
	always_comb begin
		q_item.refused = 1'b0;
		q_item.stop_lv = stop_level;
		case (op)
			OP_CTRL_TICK:  q_item.cmd = CMD_CTRL_TICK;
			OP_DELAY_TICK: q_item.cmd = CMD_DELAY_TICK;
			OP_START: begin
				q_item.cmd     = CMD_START;
				q_item.refused = start_bad;
			end
			OP_STOP:       q_item.cmd = CMD_STOP;
			OP_EMERGENCY:  q_item.cmd = CMD_EMERGENCY;
			OP_REDUCE_EDG: q_item.cmd = (cfg.mode_bits[MB_S_REDUCE] && event_level) ?
				CMD_REDUCE_EDGE : CMD_NOP;
			OP_STOP_EDG:   q_item.cmd = (cfg.mode_bits[MB_S_STOP] && event_level) ?
				CMD_STOP_EDGE : CMD_NOP;
			default:       q_item.cmd = CMD_NOP;
		endcase
	end

endmodule

// ===== design/mdr_queue.sv =====
// Short command queue between front and back ends.
// Depends on mdr_pkg for the item type.
module mdr_queue import mdr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t pop_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== design/mdr_back.sv =====
// Back end: carries out queued commands on the profile state and holds the result.
// Depends on mdr_pkg; the state registers double as the result register.
module mdr_back import mdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_not_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DUTY_W-1:0] duty,
	output logic              direction,
	output logic              brake_on,
	output phase_t            motor_state,
	output logic              stable_event,
	output logic              fault,
	output logic              start_refused
);

	phase_t            phase_q, ph;
	logic [DUTY_W-1:0] duty_q, du;
	logic [DUTY_W-1:0] delay_q, dl;
	logic              brake_q, br;
	logic              dir_q, dr;
	logic              fault_q, ft;
	logic              stable_q, st;
	logic              refused_q;
	logic              valid_q;
	logic [DUTY_W:0]   sum;
	logic              active;

	// Pop when the result slot is free or drains this cycle
	assign q_pop = q_not_empty && (!valid_q || out_ready);

	assign sum    = {1'b0, duty_q} + {1'b0, cfg.gain_step};
	assign active = (phase_q != PH_IDLE) && (phase_q != PH_STOP);

	// Next profile state for the command at the queue head
	always_comb begin
		ph = phase_q;
		du = duty_q;
		dl = delay_q;
		br = brake_q;
		dr = dir_q;
		ft = fault_q;
		st = 1'b0;
		case (q_item.cmd)
			CMD_CTRL_TICK: begin
				if (phase_q == PH_GAINED) begin
					if (duty_q >= cfg.high_duty) begin
						du = cfg.high_duty;
						ph = PH_CONST;
						st = 1'b1;
					end else begin
						du = sum[DUTY_W] ? '1 : sum[DUTY_W-1:0];
					end
				end else if (phase_q == PH_REDUCE) begin
					if (cfg.reduce_step != '0 && duty_q > cfg.reduce_step &&
					    duty_q > cfg.reduce_floor) begin
						du = duty_q - cfg.reduce_step;
					end else begin
						du = '0;
						ph = PH_BREAK;
					end
				end
				if (ph == PH_BREAK) begin
					if (cfg.mode_bits[MB_BRAKE]) br = 1'b1;
					if (cfg.mode_bits[MB_BRAKE] && cfg.break_time != '0) begin
						dl = cfg.break_time;
						ph = PH_BREAKING;
					end else begin
						ph = PH_STOPPING;
					end
				end
				if (ph == PH_STOPPING) begin
					if (!cfg.mode_bits[MB_KEEP]) br = 1'b0;
					ph = PH_STOP;
				end
				// Final stop sensor check on arrival at stop
				if (phase_q != PH_STOP && ph == PH_STOP && cfg.mode_bits[MB_CHKSTOP] &&
				    cfg.mode_bits[MB_S_STOP] && !q_item.stop_lv)
					ft = 1'b1;
			end
			CMD_DELAY_TICK: begin
				if (delay_q != '0) begin
					dl = delay_q - 1'b1;
					if (delay_q == DUTY_W'(1)) begin
						if (phase_q == PH_OVERRUN) ph = PH_REDUCE;
						else if (phase_q == PH_BREAKING) ph = PH_STOPPING;
					end
				end
			end
			CMD_START: begin
				if (!q_item.refused) begin
					dr = cfg.mode_bits[MB_DIR];
					if (cfg.gain_step != '0) begin
						du = cfg.start_duty;
						ph = PH_GAINED;
					end else begin
						du = cfg.high_duty;
						ph = PH_CONST;
					end
					ft = 1'b0;
				end
			end
			CMD_STOP, CMD_REDUCE_EDGE: begin
				if ((q_item.cmd == CMD_STOP && phase_q != PH_IDLE) ||
				    (q_item.cmd == CMD_REDUCE_EDGE && active && phase_q < PH_REDUCE)) begin
					if (cfg.overrun_time != '0) begin
						dl = cfg.overrun_time;
						ph = PH_OVERRUN;
					end else begin
						ph = PH_REDUCE;
					end
				end
			end
			CMD_EMERGENCY: begin
				du = '0;
				ph = PH_BREAK;
			end
			CMD_STOP_EDGE: begin
				if (active && phase_q < PH_BREAK) begin
					du = '0;
					ph = PH_BREAK;
				end
			end
			default: ;
		endcase
	end

	// Control state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			duty_q    <= '0;
			delay_q   <= '0;
			brake_q   <= 1'b0;
			dir_q     <= 1'b0;
			fault_q   <= 1'b0;
			stable_q  <= 1'b0;
			refused_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q   <= ph;
				duty_q    <= du;
				delay_q   <= dl;
				brake_q   <= br;
				dir_q     <= dr;
				fault_q   <= ft;
				stable_q  <= st;
				refused_q <= (q_item.cmd == CMD_START) && q_item.refused;
				valid_q   <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = valid_q;
	assign duty          = duty_q;
	assign direction     = dir_q;
	assign brake_on      = brake_q;
	assign motor_state   = phase_q;
	assign stable_event  = stable_q;
	assign fault         = fault_q;
	assign start_refused = refused_q;

endmodule

// ===== design/motor_duty_ramp_profile.sv =====
// Motor duty ramp profile controller, top level.
// Depends on mdr_pkg, mdr_front, mdr_queue, mdr_back and the defines header.
//
// Usage:
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   registers in order start_duty, gain_step, high_duty, overrun_time,
//   reduce_step, reduce_floor, break_time, mode_bits. Write only while idle.
//   Input channel (in_valid/in_ready): one beat per command op with the
//   event level and current sensor levels.
//   Output channel (out_valid/out_ready): one result beat per input beat,
//   in order: duty, direction, brake_on, motor_state, stable_event, fault,
//   start_refused.
// Timing:
//   One beat per cycle sustained while results are taken. A beat accepted
//   passes the queue write, then the back end state update that also forms
//   the result register, before its result shows.
//   Throughput is set by the single state update in the back end.
// Reset: arst_n clears configuration, profile state (idle, duty 0, brake off)
//   and the queue; no result is pending.
// Stall: a held result stalls the back end; the front keeps taking beats
//   until the QUEUE_DEPTH_P-entry queue fills, then drops in_ready.
`include "motor_duty_ramp_profile_defines.svh"
module motor_duty_ramp_profile import mdr_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DUTY_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      op,
	input  logic                 event_level,
	input  logic                 start_level,
	input  logic                 reduce_level,
	input  logic                 stop_level,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DUTY_W-1:0]    duty,
	output logic                 direction,
	output logic                 brake_on,
	output logic [3:0]           motor_state,
	output logic                 stable_event,
	output logic                 fault,
	output logic                 start_refused
);

	cfg_t   cfg_q;
	logic   q_full, q_push, q_pop, q_not_empty;
	item_t  q_in, q_out;
	phase_t phase;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_DUTY:   cfg_q.start_duty   <= cfg_data;
				REG_GAIN_STEP:    cfg_q.gain_step    <= cfg_data;
				REG_HIGH_DUTY:    cfg_q.high_duty    <= cfg_data;
				REG_OVERRUN_TIME: cfg_q.overrun_time <= cfg_data;
				REG_REDUCE_STEP:  cfg_q.reduce_step  <= cfg_data;
				REG_REDUCE_FLOOR: cfg_q.reduce_floor <= cfg_data;
				REG_BREAK_TIME:   cfg_q.break_time   <= cfg_data;
				REG_MODE_BITS:    cfg_q.mode_bits    <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	mdr_front u_front (
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.event_level  (event_level),
		.start_level  (start_level),
		.reduce_level (reduce_level),
		.stop_level   (stop_level),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_in)
	);

	mdr_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (q_out)
	);

	mdr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_not_empty   (q_not_empty),
		.q_item        (q_out),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty          (duty),
		.direction     (direction),
		.brake_on      (brake_on),
		.motor_state   (phase),
		.stable_event  (stable_event),
		.fault         (fault),
		.start_refused (start_refused)
	);

	assign motor_state = phase;

	// An accepted beat sits in the queue or has produced a result
	`MDR_ASSERT_NXT(a_beat_kept, in_valid && in_ready, q_not_empty || out_valid)
	// Nothing drives the motor before the first start
	`MDR_ASSERT_IMP(a_idle_quiet, phase == PH_IDLE, duty == '0 && !brake_on)
	// While braking, stopping or stopped the duty is zero
	`MDR_ASSERT_IMP(a_brake_zero,
		phase == PH_BREAKING || phase == PH_STOPPING || phase == PH_STOP, duty == '0)
	// The stable mark only comes with the ramp landing on high duty
	`MDR_ASSERT_IMP(a_stable_const, out_valid && stable_event,
		phase == PH_CONST && duty == cfg_q.high_duty)

endmodule
